// ----- src/asm_line_field_splitter_defines.svh -----
// assertion macros for the line field splitter
`ifndef ASM_LINE_FIELD_SPLITTER_DEFINES_SVH
`define ASM_LINE_FIELD_SPLITTER_DEFINES_SVH

// condition on this edge implies consequence on the same edge
`define ASMLFS_ASSERT_NOW(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("asm_line_field_splitter: same-cycle check failed");

// condition on this edge implies consequence on the next edge
`define ASMLFS_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("asm_line_field_splitter: next-cycle check failed");

`endif

// ----- src/asmlfs_pkg.sv -----
package asmlfs_pkg;

  localparam int LINE_LEN    = 256;
  localparam int LABEL_LEN   = 32;
  localparam int OPERAND_LEN = 64;
  localparam int MNEM_LEN    = 32;

  localparam int LINE_CNT_W = $clog2(LINE_LEN);
  localparam int FIELD_LEN_MAX0 = (LABEL_LEN > MNEM_LEN) ? LABEL_LEN : MNEM_LEN;
  localparam int FIELD_LEN_MAX = (FIELD_LEN_MAX0 > OPERAND_LEN) ? FIELD_LEN_MAX0 : OPERAND_LEN;
  localparam int FIELD_CNT_W = $clog2(FIELD_LEN_MAX);

  localparam logic [LINE_CNT_W-1:0]  LINE_MAX    = LINE_CNT_W'(LINE_LEN - 1);
  localparam logic [FIELD_CNT_W-1:0] LABEL_MAX   = FIELD_CNT_W'(LABEL_LEN - 1);
  localparam logic [FIELD_CNT_W-1:0] MNEM_MAX    = FIELD_CNT_W'(MNEM_LEN - 1);
  localparam logic [FIELD_CNT_W-1:0] OPERAND_MAX = FIELD_CNT_W'(OPERAND_LEN - 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  localparam logic [1:0] FIELD_LABEL = 2'd0;
  localparam logic [1:0] FIELD_MNEM  = 2'd1;
  localparam logic [1:0] FIELD_OP1   = 2'd2;
  localparam logic [1:0] FIELD_OP2   = 2'd3;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [5:0] HELD_MAX = 6'd63;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       ends_line;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] field_id;
    logic [7:0] out_char;
    logic [5:0] spaces_before;
    logic       label_found;
    logic       has_mnemonic;
    logic       has_op1;
    logic       has_op2;
    logic       last;
  } result_t;

endpackage

// ----- src/asm_line_field_splitter.sv -----
// Splits an assembler source stream, one character per item, into label,
// mnemonic, operand1 and operand2 fields. An item is accepted in every cycle
// while the four-entry result queue has room for two more results
// (ready is high when it holds two or fewer); the line state is updated in
// the accepting cycle and the item's results (a stored character, a line
// summary, both or none) enter the queue at once. While result_ready is
// high the queue drains one result per cycle and items that yield at most
// one result sustain one item per cycle; an item with both takes two entries.
`include "asm_line_field_splitter_defines.svh"

module asm_line_field_splitter (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  asmlfs_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output asmlfs_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_START,
    PH_LABEL,
    PH_SKIP1,
    PH_MNEM,
    PH_SKIP2,
    PH_OPER
  } phase_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == asmlfs_pkg::CH_SPACE) ||
           (b >= asmlfs_pkg::CH_TAB && b <= asmlfs_pkg::CH_CR);
  endfunction

  phase_t                             phase, phase_next;
  logic [1:0]                         comment_quotes, comment_quotes_next;
  logic [1:0]                         operand_quotes, operand_quotes_next;
  logic signed [8:0]                  paren_depth, paren_depth_next;
  logic                               comma_seen, comma_seen_next;
  logic                               in_comment, in_comment_next;
  logic [asmlfs_pkg::FIELD_CNT_W-1:0] field_raw_count, field_raw_count_next;
  logic [5:0]                         held_spaces, held_spaces_next;
  logic [asmlfs_pkg::LINE_CNT_W-1:0]  line_count, line_count_next;
  logic [3:0]                         presence_flags, presence_flags_next;

  logic                accept;
  logic                emit;
  logic                done;
  logic                bit_sel;
  logic [7:0]          c;
  logic [1:0]          emit_fid;
  logic [7:0]          emit_char;
  logic [5:0]          emit_sp;
  logic [1:0]          n_results;
  asmlfs_pkg::result_t char_res, sum_res, first_res;

  // result queue
  asmlfs_pkg::result_t fifo [4];
  logic [1:0]          rd_ptr, wr_ptr;
  logic [2:0]          count;
  logic                pop;

  assign accept       = item_valid && item_ready;
  assign item_ready   = (count <= 3'd2);
  assign result_valid = (count != 3'd0);
  assign result       = fifo[rd_ptr];
  assign pop          = result_valid && result_ready;

  always_comb begin
    phase_next           = phase;
    comment_quotes_next  = comment_quotes;
    operand_quotes_next  = operand_quotes;
    paren_depth_next     = paren_depth;
    comma_seen_next      = comma_seen;
    in_comment_next      = in_comment;
    field_raw_count_next = field_raw_count;
    held_spaces_next     = held_spaces;
    line_count_next      = line_count;
    presence_flags_next  = presence_flags;
    c         = item.ch;
    emit      = 1'b0;
    done      = 1'b0;
    bit_sel   = 1'b0;
    emit_fid  = asmlfs_pkg::FIELD_LABEL;
    emit_char = c;
    emit_sp   = 6'd0;

    if (item.has_char) begin
      if (line_count_next >= asmlfs_pkg::LINE_MAX) begin
        done = 1'b1;
      end else begin
        line_count_next = line_count_next + 1'b1;
      end
      if (!done && in_comment_next) begin
        done = 1'b1;
      end
      if (!done && c == asmlfs_pkg::CH_NUL) begin
        in_comment_next = 1'b1;
        done = 1'b1;
      end
      if (!done) begin
        if (c == asmlfs_pkg::CH_SQUOTE && !comment_quotes_next[1]) begin
          comment_quotes_next[0] = ~comment_quotes_next[0];
        end else if (c == asmlfs_pkg::CH_DQUOTE && !comment_quotes_next[0]) begin
          comment_quotes_next[1] = ~comment_quotes_next[1];
        end else if (c == asmlfs_pkg::CH_SEMI && comment_quotes_next == 2'b00) begin
          in_comment_next = 1'b1;
          done = 1'b1;
        end
      end
      if (!done && phase_next == PH_START) begin
        if (is_blank(c)) begin
          phase_next = PH_SKIP1;
          done = 1'b1;
        end else begin
          phase_next = PH_LABEL;
          field_raw_count_next = '0;
        end
      end
      if (!done && phase_next == PH_LABEL) begin
        done = 1'b1;
        if (is_blank(c) || c == asmlfs_pkg::CH_COLON) begin
          phase_next = PH_SKIP1;
        end else if (field_raw_count_next < asmlfs_pkg::LABEL_MAX) begin
          field_raw_count_next = field_raw_count_next + 1'b1;
          presence_flags_next[0] = 1'b1;
          emit = 1'b1;
          emit_fid = asmlfs_pkg::FIELD_LABEL;
        end
      end
      if (!done && phase_next == PH_SKIP1) begin
        if (is_blank(c)) begin
          done = 1'b1;
        end else begin
          phase_next = PH_MNEM;
          field_raw_count_next = '0;
        end
      end
      if (!done && phase_next == PH_MNEM) begin
        if (is_blank(c)) begin
          phase_next = PH_SKIP2;
          done = 1'b1;
        end else if (c == asmlfs_pkg::CH_COMMA) begin
          // leading comma: empty mnemonic, comma goes to operand logic
          phase_next = PH_OPER;
          field_raw_count_next = '0;
        end else begin
          done = 1'b1;
          if (field_raw_count_next < asmlfs_pkg::MNEM_MAX) begin
            field_raw_count_next = field_raw_count_next + 1'b1;
            presence_flags_next[1] = 1'b1;
            emit = 1'b1;
            emit_fid = asmlfs_pkg::FIELD_MNEM;
            if (c >= asmlfs_pkg::CH_LOW_A && c <= asmlfs_pkg::CH_LOW_Z) begin
              emit_char = c - asmlfs_pkg::CASE_DIFF;
            end
          end
        end
      end
      if (!done && phase_next == PH_SKIP2) begin
        if (is_blank(c)) begin
          done = 1'b1;
        end else begin
          phase_next = PH_OPER;
          field_raw_count_next = '0;
        end
      end
      if (!done) begin
        if (c == asmlfs_pkg::CH_SQUOTE && !operand_quotes_next[1]) begin
          operand_quotes_next[0] = ~operand_quotes_next[0];
        end else if (c == asmlfs_pkg::CH_DQUOTE && !operand_quotes_next[0]) begin
          operand_quotes_next[1] = ~operand_quotes_next[1];
        end else if (operand_quotes_next == 2'b00) begin
          if (c == asmlfs_pkg::CH_LPAREN) begin
            if (paren_depth_next < 9'sd255) paren_depth_next = paren_depth_next + 9'sd1;
          end else if (c == asmlfs_pkg::CH_RPAREN) begin
            if (paren_depth_next > -9'sd255) paren_depth_next = paren_depth_next - 9'sd1;
          end else if (c == asmlfs_pkg::CH_COMMA && paren_depth_next == 9'sd0 &&
                       !comma_seen_next) begin
            comma_seen_next = 1'b1;
            field_raw_count_next = '0;
            held_spaces_next = 6'd0;
            done = 1'b1;
          end
        end
      end
      if (!done) begin
        done = 1'b1;
        bit_sel = comma_seen_next;
        if (field_raw_count_next < asmlfs_pkg::OPERAND_MAX) begin
          field_raw_count_next = field_raw_count_next + 1'b1;
          if (is_blank(c)) begin
            // blanks are held until a later stored character of the field
            if (presence_flags_next[{1'b1, bit_sel}] &&
                held_spaces_next < asmlfs_pkg::HELD_MAX) begin
              held_spaces_next = held_spaces_next + 6'd1;
            end
          end else begin
            emit = 1'b1;
            emit_fid = bit_sel ? asmlfs_pkg::FIELD_OP2 : asmlfs_pkg::FIELD_OP1;
            emit_sp = presence_flags_next[{1'b1, bit_sel}] ? held_spaces_next : 6'd0;
            held_spaces_next = 6'd0;
            presence_flags_next[{1'b1, bit_sel}] = 1'b1;
          end
        end
      end
    end

    char_res               = '0;
    char_res.kind          = asmlfs_pkg::KIND_CHAR;
    char_res.field_id      = emit_fid;
    char_res.out_char      = emit_char;
    char_res.spaces_before = emit_sp;
    char_res.last          = !item.ends_line;

    sum_res              = '0;
    sum_res.kind         = asmlfs_pkg::KIND_SUMMARY;
    sum_res.label_found  = presence_flags_next[0];
    sum_res.has_mnemonic = presence_flags_next[1];
    sum_res.has_op1      = presence_flags_next[2];
    sum_res.has_op2      = presence_flags_next[3];
    sum_res.last         = 1'b1;

    first_res = emit ? char_res : sum_res;
    n_results = {1'b0, emit} + {1'b0, item.ends_line};

    if (item.ends_line) begin
      phase_next           = PH_START;
      comment_quotes_next  = 2'b00;
      operand_quotes_next  = 2'b00;
      paren_depth_next     = 9'sd0;
      comma_seen_next      = 1'b0;
      in_comment_next      = 1'b0;
      field_raw_count_next = '0;
      held_spaces_next     = 6'd0;
      line_count_next      = '0;
      presence_flags_next  = 4'b0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      comment_quotes  <= 2'b00;
      operand_quotes  <= 2'b00;
      paren_depth     <= 9'sd0;
      comma_seen      <= 1'b0;
      in_comment      <= 1'b0;
      field_raw_count <= '0;
      held_spaces     <= 6'd0;
      line_count      <= '0;
      presence_flags  <= 4'b0000;
      rd_ptr          <= 2'd0;
      wr_ptr          <= 2'd0;
      count           <= 3'd0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        comment_quotes  <= comment_quotes_next;
        operand_quotes  <= operand_quotes_next;
        paren_depth     <= paren_depth_next;
        comma_seen      <= comma_seen_next;
        in_comment      <= in_comment_next;
        field_raw_count <= field_raw_count_next;
        held_spaces     <= held_spaces_next;
        line_count      <= line_count_next;
        presence_flags  <= presence_flags_next;
        wr_ptr          <= wr_ptr + n_results;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, (accept ? n_results : 2'd0)} - {2'b00, pop};
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && n_results != 2'd0) begin
      fifo[wr_ptr] <= first_res;
      if (n_results == 2'd2) begin
        fifo[wr_ptr + 2'd1] <= sum_res;
      end
    end
  end

  `ASMLFS_ASSERT_NEXT(a_line_end_clears, clk, rst, accept && item.ends_line,
                      phase == PH_START && presence_flags == 4'b0000 && line_count == '0)
  `ASMLFS_ASSERT_NEXT(a_queue_no_overflow, clk, rst, accept, count <= 3'd4)
  `ASMLFS_ASSERT_NOW(a_summary_is_last, clk, rst, result_valid && result.kind,
                     result.last && result.out_char == 8'd0)
  `ASMLFS_ASSERT_NOW(a_ready_needs_room, clk, rst, item_ready, count <= 3'd2)

endmodule

// ----- tb/asm_line_field_splitter_checker.sv -----
`timescale 1ns / 100ps

module asm_line_field_splitter_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  asmlfs_pkg::item_t   item,
  input  logic                result_valid,
  input  logic                result_ready,
  input  asmlfs_pkg::result_t result,
  output int                  mismatches,
  output int                  pending
);

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_LABEL,
    SCAN_GAP1,
    SCAN_MNEM,
    SCAN_GAP2,
    SCAN_OPER
  } scan_phase_t;

  // line state of the field splitter
  scan_phase_t phase;
  logic [1:0]  text_quotes;   // bit0 single, bit1 double
  logic [1:0]  oper_quotes;
  int          depth;
  bit          comma_seen;
  bit          in_comment;
  int          raw_cnt;
  int          held;
  int          line_pos;
  logic [3:0]  present;       // label, mnemonic, op1, op2

  asmlfs_pkg::result_t field_expect_q[$];
  asmlfs_pkg::result_t want;
  bit                  bad;

  function automatic bit is_blank(logic [7:0] c);
    return c == asmlfs_pkg::CH_SPACE ||
           (c >= asmlfs_pkg::CH_TAB && c <= asmlfs_pkg::CH_CR);
  endfunction

  function automatic string show(asmlfs_pkg::result_t r);
    return $sformatf("kind=%0d field=%0d char=%02h sp=%0d flags=%b last=%0d",
                     r.kind, r.field_id, r.out_char, r.spaces_before,
                     {r.label_found, r.has_mnemonic, r.has_op1, r.has_op2}, r.last);
  endfunction

  task automatic clear_line();
    phase       = SCAN_START;
    text_quotes = 2'b00;
    oper_quotes = 2'b00;
    depth       = 0;
    comma_seen  = 1'b0;
    in_comment  = 1'b0;
    raw_cnt     = 0;
    held        = 0;
    line_pos    = 0;
    present     = 4'b0000;
  endtask

  task automatic scan_char(input logic [7:0] c_in, output bit stored,
                           output asmlfs_pkg::result_t r);
    logic [7:0] c;
    logic [1:0] fid;
    int         bit_idx;
    c      = c_in;
    stored = 1'b0;
    r      = '0;
    r.kind = asmlfs_pkg::KIND_CHAR;
    if (line_pos >= asmlfs_pkg::LINE_LEN - 1) return;
    line_pos++;
    if (in_comment) return;
    if (c == asmlfs_pkg::CH_NUL) begin
      in_comment = 1'b1;
      return;
    end
    if (c == asmlfs_pkg::CH_SQUOTE && !text_quotes[1]) text_quotes[0] = ~text_quotes[0];
    else if (c == asmlfs_pkg::CH_DQUOTE && !text_quotes[0]) text_quotes[1] = ~text_quotes[1];
    else if (c == asmlfs_pkg::CH_SEMI && text_quotes == 2'b00) begin
      in_comment = 1'b1;
      return;
    end

    if (phase == SCAN_START) begin
      if (is_blank(c)) begin
        phase = SCAN_GAP1;
        return;
      end
      phase   = SCAN_LABEL;
      raw_cnt = 0;
    end
    if (phase == SCAN_LABEL) begin
      if (is_blank(c) || c == asmlfs_pkg::CH_COLON) begin
        phase = SCAN_GAP1;
        return;
      end
      if (raw_cnt >= asmlfs_pkg::LABEL_LEN - 1) return;
      raw_cnt++;
      present[0] = 1'b1;
      r.field_id = asmlfs_pkg::FIELD_LABEL;
      r.out_char = c;
      stored     = 1'b1;
      return;
    end
    if (phase == SCAN_GAP1) begin
      if (is_blank(c)) return;
      phase   = SCAN_MNEM;
      raw_cnt = 0;
    end
    if (phase == SCAN_MNEM) begin
      if (is_blank(c)) begin
        phase = SCAN_GAP2;
        return;
      end
      if (c == asmlfs_pkg::CH_COMMA) begin
        // empty mnemonic, the comma goes on to split the operands
        phase   = SCAN_OPER;
        raw_cnt = 0;
      end else begin
        if (raw_cnt >= asmlfs_pkg::MNEM_LEN - 1) return;
        raw_cnt++;
        present[1] = 1'b1;
        if (c >= asmlfs_pkg::CH_LOW_A && c <= asmlfs_pkg::CH_LOW_Z)
          c = c - asmlfs_pkg::CASE_DIFF;
        r.field_id = asmlfs_pkg::FIELD_MNEM;
        r.out_char = c;
        stored     = 1'b1;
        return;
      end
    end
    if (phase == SCAN_GAP2) begin
      if (is_blank(c)) return;
      phase   = SCAN_OPER;
      raw_cnt = 0;
    end

    if (c == asmlfs_pkg::CH_SQUOTE && !oper_quotes[1]) oper_quotes[0] = ~oper_quotes[0];
    else if (c == asmlfs_pkg::CH_DQUOTE && !oper_quotes[0]) oper_quotes[1] = ~oper_quotes[1];
    else if (oper_quotes == 2'b00) begin
      if (c == asmlfs_pkg::CH_LPAREN) begin
        if (depth < 255) depth++;
      end else if (c == asmlfs_pkg::CH_RPAREN) begin
        if (depth > -255) depth--;
      end else if (c == asmlfs_pkg::CH_COMMA && depth == 0 && !comma_seen) begin
        comma_seen = 1'b1;
        raw_cnt    = 0;
        held       = 0;
        return;
      end
    end
    if (raw_cnt >= asmlfs_pkg::OPERAND_LEN - 1) return;
    raw_cnt++;
    fid     = comma_seen ? asmlfs_pkg::FIELD_OP2 : asmlfs_pkg::FIELD_OP1;
    bit_idx = comma_seen ? 3 : 2;
    if (is_blank(c)) begin
      // blanks only count once the operand has started
      if (present[bit_idx] && held < asmlfs_pkg::HELD_MAX) held++;
      return;
    end
    r.field_id      = fid;
    r.out_char      = c;
    r.spaces_before = present[bit_idx] ? 6'(held) : 6'd0;
    held             = 0;
    present[bit_idx] = 1'b1;
    stored           = 1'b1;
  endtask

  task automatic split_item(input asmlfs_pkg::item_t it);
    asmlfs_pkg::result_t r;
    bit                  stored;
    stored = 1'b0;
    r      = '0;
    if (it.has_char) scan_char(it.ch, stored, r);
    if (stored) begin
      r.last = !it.ends_line;
      field_expect_q.push_back(r);
    end
    if (it.ends_line) begin
      r              = '0;
      r.kind         = asmlfs_pkg::KIND_SUMMARY;
      r.label_found  = present[0];
      r.has_mnemonic = present[1];
      r.has_op1      = present[2];
      r.has_op2      = present[3];
      r.last         = 1'b1;
      field_expect_q.push_back(r);
      clear_line();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      field_expect_q.delete();
      mismatches = 0;
    end else begin
      if (item_valid && item_ready) split_item(item);
      if (result_valid && result_ready) begin
        if (field_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result %s", $time, show(result));
        end else begin
          want = field_expect_q.pop_front();
          bad = (result.kind !== want.kind) || (result.field_id !== want.field_id) ||
                (result.out_char !== want.out_char) ||
                (result.spaces_before !== want.spaces_before) ||
                (result.label_found !== want.label_found) ||
                (result.has_mnemonic !== want.has_mnemonic) ||
                (result.has_op1 !== want.has_op1) || (result.has_op2 !== want.has_op2) ||
                (result.last !== want.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected %s", $time, show(want));
              $display("%0t:          actual   %s", $time, show(result));
            end
          end
        end
      end
    end
    pending = field_expect_q.size();
  end

endmodule

// ----- tb/asm_line_field_splitter_tb.sv -----
`timescale 1ns / 100ps

module asm_line_field_splitter_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 2000;
  localparam int LONG_HOLD   = 200;
  localparam int DRAIN_WAIT  = 16;
  localparam int HOLD_START  = 800;
  localparam int HOLD_END    = 1000;

  localparam string BLANKS  = "\011\012\013\014\015 ";
  localparam string IDENT   = "abzAZ09_.'";
  localparam string LETTERS = "abcmxyzAQZ@[`{";
  localparam string OPERS   = "ab1(  )'\"\t,,x+ ";
  localparam string REMARK  = "x;'\", ";

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  asmlfs_pkg::item_t   item;
  logic                result_valid;
  logic                result_ready;
  asmlfs_pkg::result_t result;

  int mismatches;
  int pending;
  int cycles = 0;
  int items_sent = 0;
  bit steady_send = 1'b0;
  bit hold_req = 1'b0;

  logic [7:0] line_bytes[$];

  asm_line_field_splitter DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  asm_line_field_splitter_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] pick(string chars);
    return chars[$urandom_range(0, chars.len() - 1)];
  endfunction

  task automatic add_run(string chars, int n);
    repeat (n) line_bytes.push_back(pick(chars));
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic [7:0] c, input bit h, input bit e);
    asmlfs_pkg::item_t nxt;
    int                gap;
    nxt.ch        = c;
    nxt.has_char  = h;
    nxt.ends_line = e;
    gap = steady_send ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= nxt;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
    if (h || e) items_sent++;
  endtask

  task automatic send_line(input bit close_on_char);
    for (int i = 0; i < line_bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(line_bytes[i], 1'b1, close_on_char && i == line_bytes.size() - 1);
    end
    if (!close_on_char) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    line_bytes.delete();
  endtask

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int stall;
    bit steady_take;
    steady_take  = 1'b0;
    result_ready = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) steady_take = ~steady_take;
      stall = steady_take ? 0 : $urandom_range(0, 5);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    bit held_off;
    int n;
    held_off   = 1'b0;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed lines
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'ha5, 1'b0, 1'b1);
    add_text("Ab::mv");
    send_line(1'b1);
    line_bytes.push_back(asmlfs_pkg::CH_TAB);
    add_text(",)x,y");
    send_line(1'b1);
    line_bytes.push_back(8'hff);
    line_bytes.push_back(asmlfs_pkg::CH_NUL);
    line_bytes.push_back(8'h71);
    send_line(1'b1);
    add_text("n ;x");
    send_line(1'b0);

    while (items_sent < ITEM_TARGET) begin
      steady_send = ($urandom_range(0, 4) == 0) ||
                    (items_sent >= HOLD_START && items_sent < HOLD_END);
      if (!held_off && items_sent >= HOLD_START) begin
        held_off = 1'b1;
        hold_req = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) begin
        // noise line
        n = $urandom_range(1, 40);
        repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          add_run(IDENT, ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40)
                                                     : $urandom_range(1, 6));
          case ($urandom_range(0, 3))
            0: line_bytes.push_back(asmlfs_pkg::CH_COLON);
            1: add_text("::");
            default: ;
          endcase
        end
        add_run(BLANKS, $urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0) line_bytes.push_back(asmlfs_pkg::CH_COMMA);
        else add_run(LETTERS, ($urandom_range(0, 9) == 0) ? $urandom_range(29, 36)
                                                          : $urandom_range(1, 5));
        if ($urandom_range(0, 7) != 0) begin
          add_run(BLANKS, $urandom_range(1, 3));
          add_run(OPERS, ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(0, 8));
          if ($urandom_range(0, 9) == 0) add_run(" ", $urandom_range(30, 70));
          if ($urandom_range(0, 3) != 0) begin
            line_bytes.push_back(asmlfs_pkg::CH_COMMA);
            add_run(OPERS, $urandom_range(0, 8));
          end
        end
        if ($urandom_range(0, 4) == 0) begin
          line_bytes.push_back($urandom_range(0, 1) ? asmlfs_pkg::CH_SEMI
                                                    : asmlfs_pkg::CH_NUL);
          add_run(REMARK, $urandom_range(0, 6));
        end
        // overlong line
        if ($urandom_range(0, 29) == 0) begin
          n = $urandom_range(250, 280);
          repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_line($urandom_range(0, 4) != 0);
    end
    item_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/asmlfs_pkg.sv
src/asm_line_field_splitter.sv
tb/asm_line_field_splitter_checker.sv
tb/asm_line_field_splitter_tb.sv
